[design/video_sync_capture_analyzer_macros.svh]
// assertion macros used by the capture analyzer rtl
// no dependencies; include by bare file name inside a module body clocked by i_clk
`ifndef VIDEO_SYNC_CAPTURE_ANALYZER_MACROS_SVH
`define VIDEO_SYNC_CAPTURE_ANALYZER_MACROS_SVH

// same-cycle implication on i_clk, checked outside reset
`define VSCA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, checked outside reset
`define VSCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vsca_pkg.sv]
// types, constants and the sync edge tracker for the capture analyzer
// no dependencies
`default_nettype none

package vsca_pkg;

    localparam int MAX_COLS   = 2048;
    localparam int MAX_ROWS   = 2048;
    localparam int WIDTH_BITS = 24;
    localparam int CNT_W      = 12;
    localparam int WIN_W      = CNT_W + 1;
    localparam int ADDR_W     = 22;
    localparam int PIX_W      = 8;
    localparam int POL_W      = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 2;

    localparam logic [POL_W-1:0] POL_LOW     = 2'd0;
    localparam logic [POL_W-1:0] POL_HIGH    = 2'd1;
    localparam logic [POL_W-1:0] POL_UNKNOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 2'd1;

    localparam logic [CNT_W-1:0]      CNT_MAX = {CNT_W{1'b1}};
    localparam logic [WIDTH_BITS-1:0] RUN_MAX = {WIDTH_BITS{1'b1}};

    typedef struct packed {
        logic                  prev;
        logic [WIDTH_BITS-1:0] run;
        logic [WIDTH_BITS-1:0] lo;
        logic [WIDTH_BITS-1:0] hi;
        logic [POL_W-1:0]      pol;
    } t_sync_state;

    typedef struct packed {
        logic        hit;
        t_sync_state st;
    } t_sync_step;

    // one sample of a sync line: edge detect, run length, width and polarity learning
    function automatic t_sync_step f_track(input logic level, input t_sync_state cur);
        t_sync_step nx;
        nx.hit = 1'b0;
        nx.st  = cur;
        if (level != cur.prev) begin
            nx.hit = 1'b1;
            if (level) begin
                nx.st.lo = cur.run;
            end else begin
                nx.st.hi = cur.run;
            end
            if (cur.pol == POL_UNKNOWN && nx.st.lo != '0 && nx.st.hi != '0) begin
                if (nx.st.lo > nx.st.hi) begin
                    nx.st.pol = POL_HIGH;
                end else if (nx.st.lo < nx.st.hi) begin
                    nx.st.pol = POL_LOW;
                end
            end
            nx.st.prev = level;
            nx.st.run  = '0;
        end else if (cur.run != RUN_MAX) begin
            nx.st.run = cur.run + 1'b1;
        end
        return nx;
    endfunction

endpackage

`default_nettype wire

[design/video_sync_capture_analyzer.sv]
// video sync capture analyzer: one sample per cycle sustained while the result
// stream takes results; input register, one pass of sync/window
// logic with a 12x13 multiply for the address, then the result register.
// a new sample is taken while a result waits, as long as the input register is free.
// reset (synchronous, active low) clears valids, sync trackers, counters,
// polarities to unknown, latched counts to all ones and the window to 640 x 480
`default_nettype none

module video_sync_capture_analyzer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [vsca_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [vsca_pkg::CNT_W-1:0]        i_cfg_data,
    // sample stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [0] vsync_in, [1] hsync_in, [9:2] pixel_in, [15:10] zero
    input  wire logic [vsca_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // result stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [0] write_enable, [22:1] write_address, [30:23] write_data,
    // [32:31] h_polarity, [34:33] v_polarity, [46:35] visible_cols,
    // [58:47] sync_cols, [70:59] visible_rows, [82:71] sync_rows, [87:83] zero
    output logic [vsca_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,   // line_end
    output logic                                   o_m_axis_tuser    // frame_end
);
    import vsca_pkg::*;

    // configuration
    logic [CNT_W-1:0] r_active_cols;
    logic [CNT_W-1:0] r_active_rows;

    // input register
    logic             r_in_valid;
    logic             r_in_vs;
    logic             r_in_hs;
    logic [PIX_W-1:0] r_in_pix;

    // analyzer state
    t_sync_state r_vsync, n_vsync;
    t_sync_state r_hsync, n_hsync;
    logic [CNT_W-1:0] r_row_count, n_row_count;
    logic [CNT_W-1:0] r_col_count, n_col_count;
    logic [CNT_W-1:0] r_cols_before, n_cols_before;
    logic [CNT_W-1:0] r_rows_before, n_rows_before;
    logic [CNT_W-1:0] r_hs_tail, n_hs_tail;
    logic [CNT_W-1:0] r_vs_tail, n_vs_tail;

    // result register
    logic              r_out_valid;
    logic              r_we, n_we;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [PIX_W-1:0]  r_data, n_data;
    logic              r_le, n_le;
    logic              r_fe, n_fe;

    logic       advance;
    logic       fire;
    t_sync_step v_step;
    t_sync_step h_step;
    logic [WIN_W-1:0] wcols;
    logic [WIN_W-1:0] wrows;
    logic [CNT_W+WIN_W-1:0] prod;

    assign o_cfg_ready     = 1'b1;
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    assign wcols = ({1'b0, r_active_cols} < WIN_W'(MAX_COLS)) ? {1'b0, r_active_cols}
                                                              : WIN_W'(MAX_COLS);
    assign wrows = ({1'b0, r_active_rows} < WIN_W'(MAX_ROWS)) ? {1'b0, r_active_rows}
                                                              : WIN_W'(MAX_ROWS);
    assign prod  = r_row_count * wcols;

    always_comb begin
        v_step        = f_track(r_in_vs, r_vsync);
        h_step        = f_track(r_in_hs, r_hsync);
        n_vsync       = v_step.st;
        n_hsync       = h_step.st;
        n_row_count   = r_row_count;
        n_col_count   = r_col_count;
        n_cols_before = r_cols_before;
        n_rows_before = r_rows_before;
        n_hs_tail     = r_hs_tail;
        n_vs_tail     = r_vs_tail;
        n_we          = 1'b0;
        n_addr        = '0;
        n_data        = '0;
        n_le          = 1'b0;
        n_fe          = 1'b0;

        // leaving the vsync pulse wins over any hsync activity
        if (v_step.hit && {1'b0, r_in_vs} != v_step.st.pol) begin
            n_fe        = 1'b1;
            n_vs_tail   = r_row_count - r_rows_before + 1'b1;
            n_row_count = '0;
            n_col_count = '0;
        end else begin
            if (v_step.hit) begin
                n_rows_before = r_row_count;
            end
            if (h_step.hit && {1'b0, r_in_hs} != h_step.st.pol) begin
                n_le        = 1'b1;
                n_row_count = (r_row_count != CNT_MAX) ? r_row_count + 1'b1 : r_row_count;
                n_hs_tail   = r_col_count - r_cols_before + 1'b1;
                n_col_count = '0;
            end else begin
                if (h_step.hit) begin
                    n_cols_before = r_col_count;
                end
                if ({1'b0, r_col_count} < wcols && {1'b0, r_row_count} < wrows) begin
                    n_we        = 1'b1;
                    n_addr      = ADDR_W'(prod + (CNT_W+WIN_W)'(r_col_count));
                    n_data      = r_in_pix;
                    n_col_count = r_col_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cols <= CNT_W'(640);
            r_active_rows <= CNT_W'(480);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ACTIVE_COLS) begin
                r_active_cols <= i_cfg_data;
            end else if (i_cfg_index == CFG_ACTIVE_ROWS) begin
                r_active_rows <= i_cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_vs  <= i_s_axis_tdata[0];
            r_in_hs  <= i_s_axis_tdata[1];
            r_in_pix <= i_s_axis_tdata[2 +: PIX_W];
        end
    end

    // state advances once per sample moved to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsync       <= '{prev: 1'b0, run: '0, lo: '0, hi: '0, pol: POL_UNKNOWN};
            r_hsync       <= '{prev: 1'b0, run: '0, lo: '0, hi: '0, pol: POL_UNKNOWN};
            r_row_count   <= '0;
            r_col_count   <= '0;
            r_cols_before <= CNT_MAX;
            r_rows_before <= CNT_MAX;
            r_hs_tail     <= CNT_MAX;
            r_vs_tail     <= CNT_MAX;
        end else if (fire) begin
            r_vsync       <= n_vsync;
            r_hsync       <= n_hsync;
            r_row_count   <= n_row_count;
            r_col_count   <= n_col_count;
            r_cols_before <= n_cols_before;
            r_rows_before <= n_rows_before;
            r_hs_tail     <= n_hs_tail;
            r_vs_tail     <= n_vs_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_we   <= n_we;
            r_addr <= n_addr;
            r_data <= n_data;
            r_le   <= n_le;
            r_fe   <= n_fe;
        end
    end

    // polarities and latched counts are state, so they already show the post-sample view
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_le;
    assign o_m_axis_tuser  = r_fe;
    assign o_m_axis_tdata  = {5'b0, r_vs_tail, r_rows_before, r_hs_tail, r_cols_before,
                              r_vsync.pol, r_hsync.pol, r_data, r_addr, r_we};

    `include "video_sync_capture_analyzer_macros.svh"

    `VSCA_ASSERT_NOW(a_single_event, r_out_valid, !(r_le && r_fe), "line and frame end together")
    `VSCA_ASSERT_NOW(a_no_write_on_event, r_out_valid && r_we, !r_le && !r_fe, "write on sync event")
    `VSCA_ASSERT_NOW(a_idle_zero, r_out_valid && !r_we, r_addr == '0 && r_data == '0, "stray write bits")
    `VSCA_ASSERT_NEXT(a_hpol_hold, r_hsync.pol != POL_UNKNOWN, $stable(r_hsync.pol), "h polarity moved")
    `VSCA_ASSERT_NEXT(a_vpol_hold, r_vsync.pol != POL_UNKNOWN, $stable(r_vsync.pol), "v polarity moved")

endmodule

`default_nettype wire
